/* hw/rtl/tgi_pkg.sv */
// shared constants, payload types and address mapping for the trilinear grid interpolator
// no dependencies

package tgi_pkg;

   localparam int GRID_NX    = 16;
   localparam int GRID_NY    = 16;
   localparam int GRID_NZ    = 16;
   localparam int MAX_COMPS  = 4;
   localparam int COMP_LIMIT = (MAX_COMPS < 4) ? MAX_COMPS : 4;

   localparam int STORE_WORDS = GRID_NX * GRID_NY * GRID_NZ * MAX_COMPS;
   localparam int ADDR_W      = $clog2(STORE_WORDS);

   localparam int GRID_MAX = (GRID_NX > GRID_NY) ?
                             ((GRID_NX > GRID_NZ) ? GRID_NX : GRID_NZ) :
                             ((GRID_NY > GRID_NZ) ? GRID_NY : GRID_NZ);
   localparam int CELL_W   = $clog2(GRID_MAX);

   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int IDX_W     = 4;
   localparam int COMP_W    = 2;
   localparam int NCOMP_W   = 3;
   localparam int CSR_IDX_W = 3;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_ORIGIN_Z   = 3'd2,
      CSR_INV_CELL_X = 3'd3,
      CSR_INV_CELL_Y = 3'd4,
      CSR_INV_CELL_Z = 3'd5,
      CSR_NUM_COMPS  = 3'd6
   } csr_index_type;

   typedef struct packed {
      op_type                   op;
      logic [IDX_W-1:0]         cell_i;
      logic [IDX_W-1:0]         cell_j;
      logic [IDX_W-1:0]         cell_k;
      logic [COMP_W-1:0]        comp_sel;
      logic signed [DATA_W-1:0] sample_value;
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [COMP_W-1:0]        comp_out;
      logic signed [DATA_W-1:0] interp_value;
      logic                     out_of_range;
      logic                     last;
   } rsp_type;

   function automatic logic [ADDR_W-1:0] grid_addr(input int unsigned i,
                                                   input int unsigned j,
                                                   input int unsigned k,
                                                   input int unsigned c);
      int unsigned a;
      a = ((k * GRID_NY + j) * GRID_NX + i) * MAX_COMPS + c;
      return a[ADDR_W-1:0];
   endfunction

endpackage

/* hw/rtl/trilinear_grid_interpolator_core.sv */
// top level of the trilinear grid interpolator: csr bank, grid memory, locate and sequencing
// depends on tgi_pkg and tgi_lerp

// A write transaction (op 0) stores one sample in the grid memory at the accept edge and
// produces no result; busy stays low. A query transaction (op 1) raises busy and returns
// num_comps results (clamped to 1..4), one strobed cycle each, the final one flagged by last.
// Locating the point steps the three axes in turn through one shared 32x32 multiplier
// (offset, product, then cell and fraction). An out-of-range query then emits one result
// per cycle. An in-range query takes each component in turn: 8 corner reads through the
// single memory read port into a registered read data word, then 7 blends through the
// shared blend unit. Results cannot be held off and must be taken when strobed. The grid
// memory is not cleared; reading a sample never written gives any value.

module trilinear_grid_interpolator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  tgi_pkg::req_type                     req_data,
   output logic                                 rsp_strobe,
   output tgi_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [tgi_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tgi_pkg::DATA_W-1:0]           csr_wdata
);

   localparam int QDEPTH = 8;
   localparam int QCNT_W = $clog2(QDEPTH) + 1;
   localparam int LAST_STEP = 6;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOCATE = 5'b00010,
      ST_READ   = 5'b00100,
      ST_LERP   = 5'b01000,
      ST_RANGE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic signed [tgi_pkg::DATA_W-1:0] org_ff [3];
   logic [tgi_pkg::DATA_W-1:0]        inv_ff [3];
   logic [tgi_pkg::NCOMP_W-1:0]       ncfg_ff;

   logic signed [tgi_pkg::DATA_W-1:0] pos_ff [3];
   logic [1:0]                        ax_ff, ax_in;
   logic [1:0]                        ph_ff, ph_in;
   logic signed [tgi_pkg::DATA_W:0]   diff_ff;
   logic                              dneg_ff;
   logic [2*tgi_pkg::DATA_W-1:0]      prod_ff;
   logic [tgi_pkg::CELL_W-1:0]        cell_ff [3];
   logic [tgi_pkg::FRAC_W-1:0]        frac_ff [3];
   logic                              ok_ff, ok_in;
   logic [tgi_pkg::COMP_W-1:0]        comp_ff, comp_in;
   logic [tgi_pkg::NCOMP_W-1:0]       ncomp_ff, ncomp_in;
   logic [3:0]                        rcnt_ff, rcnt_in;
   logic                              rdv_ff;
   logic [2:0]                        step_ff, step_in;
   logic signed [tgi_pkg::DATA_W-1:0] q_ff [QDEPTH];
   logic [QCNT_W-1:0]                 qcnt_ff, qcnt_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   tgi_pkg::rsp_type                  rsp_ff, rsp_in;

   logic signed [tgi_pkg::DATA_W-1:0] grid_mem [tgi_pkg::STORE_WORDS];
   logic signed [tgi_pkg::DATA_W-1:0] rd_data_ff;
   logic [tgi_pkg::ADDR_W-1:0]        mem_raddr;
   logic [tgi_pkg::ADDR_W-1:0]        mem_waddr;
   logic                              mem_we;

   logic                              accept;
   logic                              rd_issue;
   logic                              q_push;
   logic                              q_pop;
   logic signed [tgi_pkg::DATA_W-1:0] q_push_data;
   logic                              lerp_start;
   logic                              lerp_done;
   logic signed [tgi_pkg::DATA_W-1:0] lerp_res;
   logic [tgi_pkg::FRAC_W-1:0]        lerp_frac;
   logic [1:0]                        lerp_ax;
   logic                              last_comp;
   logic [tgi_pkg::NCOMP_W-1:0]       nc_clamped;

   logic signed [tgi_pkg::DATA_W-1:0] pos_sel;
   logic signed [tgi_pkg::DATA_W-1:0] org_sel;
   logic [tgi_pkg::DATA_W-1:0]        inv_sel;
   logic [tgi_pkg::DATA_W-1:0]        lim_sel;
   logic [2*tgi_pkg::DATA_W-1:0]      qv;
   logic                              axis_ok;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // csr bank
   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         inv_ff[0] <= 32'h0001_0000;
         inv_ff[1] <= 32'h0001_0000;
         inv_ff[2] <= 32'h0001_0000;
         ncfg_ff   <= tgi_pkg::NCOMP_W'(1);
      end else if (csr_we) begin
         case (tgi_pkg::csr_index_type'(csr_index))
            tgi_pkg::CSR_ORIGIN_X:   org_ff[0] <= $signed(csr_wdata);
            tgi_pkg::CSR_ORIGIN_Y:   org_ff[1] <= $signed(csr_wdata);
            tgi_pkg::CSR_ORIGIN_Z:   org_ff[2] <= $signed(csr_wdata);
            tgi_pkg::CSR_INV_CELL_X: inv_ff[0] <= csr_wdata;
            tgi_pkg::CSR_INV_CELL_Y: inv_ff[1] <= csr_wdata;
            tgi_pkg::CSR_INV_CELL_Z: inv_ff[2] <= csr_wdata;
            tgi_pkg::CSR_NUM_COMPS:  ncfg_ff   <= csr_wdata[tgi_pkg::NCOMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      nc_clamped = ncfg_ff;
      if (ncfg_ff == '0) begin
         nc_clamped = tgi_pkg::NCOMP_W'(1);
      end else if (ncfg_ff > tgi_pkg::NCOMP_W'(tgi_pkg::COMP_LIMIT)) begin
         nc_clamped = tgi_pkg::NCOMP_W'(tgi_pkg::COMP_LIMIT);
      end
   end

   // grid memory
   assign mem_we = accept && (req_data.op == tgi_pkg::OP_WRITE)
                && (int'(req_data.cell_i) < tgi_pkg::GRID_NX)
                && (int'(req_data.cell_j) < tgi_pkg::GRID_NY)
                && (int'(req_data.cell_k) < tgi_pkg::GRID_NZ)
                && (int'(req_data.comp_sel) < tgi_pkg::MAX_COMPS);
   assign mem_waddr = tgi_pkg::grid_addr(int'(req_data.cell_i), int'(req_data.cell_j),
                                         int'(req_data.cell_k), int'(req_data.comp_sel));
   assign mem_raddr = tgi_pkg::grid_addr(int'(cell_ff[0]) + int'(rcnt_ff[0]),
                                         int'(cell_ff[1]) + int'(rcnt_ff[1]),
                                         int'(cell_ff[2]) + int'(rcnt_ff[2]),
                                         int'(comp_ff));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= req_data.sample_value;
      end
      rd_data_ff <= grid_mem[mem_raddr];
   end

   // locate datapath
   assign pos_sel = pos_ff[ax_ff];
   assign org_sel = org_ff[ax_ff];
   assign inv_sel = inv_ff[ax_ff];

   always_comb begin
      case (ax_ff)
         2'd0:    lim_sel = tgi_pkg::DATA_W'(tgi_pkg::GRID_NX - 2);
         2'd1:    lim_sel = tgi_pkg::DATA_W'(tgi_pkg::GRID_NY - 2);
         default: lim_sel = tgi_pkg::DATA_W'(tgi_pkg::GRID_NZ - 2);
      endcase
   end

   assign qv      = prod_ff - 64'h0000_0000_8000_0000;
   assign axis_ok = !dneg_ff && (prod_ff[2*tgi_pkg::DATA_W-1:31] != '0)
                 && (qv[2*tgi_pkg::DATA_W-1:tgi_pkg::DATA_W] <= lim_sel);

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff[0] <= req_data.pos_x;
         pos_ff[1] <= req_data.pos_y;
         pos_ff[2] <= req_data.pos_z;
      end
      if (state_ff == ST_LOCATE) begin
         case (ph_ff)
            2'd0: begin
               diff_ff <= {pos_sel[tgi_pkg::DATA_W-1], pos_sel}
                        - {org_sel[tgi_pkg::DATA_W-1], org_sel};
            end
            2'd1: begin
               dneg_ff <= diff_ff[tgi_pkg::DATA_W];
               prod_ff <= 64'(diff_ff[tgi_pkg::DATA_W-1:0]) * 64'(inv_sel);
            end
            default: begin
               cell_ff[ax_ff] <= qv[tgi_pkg::DATA_W +: tgi_pkg::CELL_W];
               frac_ff[ax_ff] <= qv[tgi_pkg::DATA_W-1 -: tgi_pkg::FRAC_W];
            end
         endcase
      end
   end

   // corner queue: reads and blend results push at the tail, each blend pops two from the head
   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int n = 0; n < QDEPTH - 2; n++) begin
            q_ff[n] <= q_ff[n + 2];
         end
      end else if (q_push) begin
         q_ff[qcnt_ff[QCNT_W-2:0]] <= q_push_data;
      end
   end

   assign lerp_ax = (step_ff < 3'd4) ? 2'd0 : ((step_ff < 3'd6) ? 2'd1 : 2'd2);
   assign lerp_frac = frac_ff[lerp_ax];

   tgi_lerp u_lerp (
      .clock  (clock),
      .reset  (reset),
      .start  (lerp_start),
      .lo     (q_ff[0]),
      .hi     (q_ff[1]),
      .frac   (lerp_frac),
      .done   (lerp_done),
      .result (lerp_res)
   );

   assign last_comp = ((tgi_pkg::NCOMP_W'(comp_ff) + tgi_pkg::NCOMP_W'(1)) == ncomp_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ax_in         = ax_ff;
      ph_in         = ph_ff;
      ok_in         = ok_ff;
      comp_in       = comp_ff;
      ncomp_in      = ncomp_ff;
      rcnt_in       = rcnt_ff;
      step_in       = step_ff;
      qcnt_in       = qcnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_issue      = 1'b0;
      q_push        = 1'b0;
      q_pop         = 1'b0;
      q_push_data   = rd_data_ff;
      lerp_start    = 1'b0;

      if (rdv_ff) begin
         q_push  = 1'b1;
         qcnt_in = qcnt_ff + QCNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.op == tgi_pkg::OP_QUERY)) begin
               state_in = ST_LOCATE;
               ax_in    = 2'd0;
               ph_in    = 2'd0;
               ok_in    = 1'b1;
               comp_in  = '0;
               ncomp_in = nc_clamped;
            end
         end
         ST_LOCATE: begin
            if (ph_ff == 2'd2) begin
               ok_in = ok_ff && axis_ok;
               ph_in = 2'd0;
               if (ax_ff == 2'd2) begin
                  rcnt_in  = '0;
                  qcnt_in  = '0;
                  state_in = (ok_ff && axis_ok) ? ST_READ : ST_RANGE;
               end else begin
                  ax_in = ax_ff + 2'd1;
               end
            end else begin
               ph_in = ph_ff + 2'd1;
            end
         end
         ST_READ: begin
            if (rcnt_ff[3]) begin
               state_in = ST_LERP;
               step_in  = '0;
               ph_in    = 2'd0;
            end else begin
               rd_issue = 1'b1;
               rcnt_in  = rcnt_ff + 4'd1;
            end
         end
         ST_LERP: begin
            if (ph_ff == 2'd0) begin
               lerp_start = 1'b1;
               q_pop      = 1'b1;
               qcnt_in    = qcnt_ff - QCNT_W'(2);
               ph_in      = 2'd1;
            end else if (lerp_done) begin
               if (step_ff == 3'(LAST_STEP)) begin
                  rsp_strobe_in       = 1'b1;
                  rsp_in.comp_out     = comp_ff;
                  rsp_in.interp_value = lerp_res;
                  rsp_in.out_of_range = 1'b0;
                  rsp_in.last         = last_comp;
                  if (last_comp) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_READ;
                     comp_in  = comp_ff + tgi_pkg::COMP_W'(1);
                     rcnt_in  = '0;
                     qcnt_in  = '0;
                  end
               end else begin
                  q_push      = 1'b1;
                  q_push_data = lerp_res;
                  qcnt_in     = qcnt_ff + QCNT_W'(1);
                  step_in     = step_ff + 3'd1;
                  ph_in       = 2'd0;
               end
            end
         end
         ST_RANGE: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.comp_out     = comp_ff;
            rsp_in.interp_value = '0;
            rsp_in.out_of_range = 1'b1;
            rsp_in.last         = last_comp;
            comp_in             = comp_ff + tgi_pkg::COMP_W'(1);
            if (last_comp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ax_ff         <= '0;
         ph_ff         <= '0;
         ok_ff         <= 1'b0;
         comp_ff       <= '0;
         ncomp_ff      <= tgi_pkg::NCOMP_W'(1);
         rcnt_ff       <= '0;
         rdv_ff        <= 1'b0;
         step_ff       <= '0;
         qcnt_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ax_ff         <= ax_in;
         ph_ff         <= ph_in;
         ok_ff         <= ok_in;
         comp_ff       <= comp_in;
         ncomp_ff      <= ncomp_in;
         rcnt_ff       <= rcnt_in;
         rdv_ff        <= rd_issue;
         step_ff       <= step_in;
         qcnt_ff       <= qcnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= QCNT_W'(QDEPTH))
      else $error("corner queue overflow");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.out_of_range |-> rsp_data.interp_value == '0)
      else $error("out-of-range result carries a nonzero value");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |=> !rsp_strobe)
      else $error("result strobe after the last result of a transaction");

   a_lerp_state: assert property (@(posedge clock) disable iff (reset)
      lerp_done |-> state_ff == ST_LERP)
      else $error("blend finished outside the blend phase");

   a_read_tail: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ && rcnt_ff[3] |-> rdv_ff && qcnt_ff == QCNT_W'(QDEPTH - 1))
      else $error("corner reads out of step with the queue");

endmodule

/* hw/rtl/tgi_lerp.sv */
// three-stage linear blend unit: lo + floor((hi - lo) * f / 2^16)
// depends on tgi_pkg

module tgi_lerp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [tgi_pkg::DATA_W-1:0] lo,
   input  logic signed [tgi_pkg::DATA_W-1:0] hi,
   input  logic [tgi_pkg::FRAC_W-1:0]        frac,
   output logic                              done,
   output logic signed [tgi_pkg::DATA_W-1:0] result
);

   localparam int PROD_W = tgi_pkg::DATA_W + tgi_pkg::FRAC_W + 2;
   localparam int SUM_W  = PROD_W - tgi_pkg::FRAC_W;

   logic                              v1_ff;
   logic                              v2_ff;
   logic signed [tgi_pkg::DATA_W:0]   diff_ff;
   logic signed [tgi_pkg::DATA_W-1:0] lo1_ff;
   logic signed [tgi_pkg::DATA_W-1:0] lo2_ff;
   logic [tgi_pkg::FRAC_W-1:0]        f_ff;
   logic signed [PROD_W-1:0]          prod_ff;
   logic [SUM_W-1:0]                  sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         diff_ff <= {hi[tgi_pkg::DATA_W-1], hi} - {lo[tgi_pkg::DATA_W-1], lo};
         lo1_ff  <= lo;
         f_ff    <= frac;
      end
      if (v1_ff) begin
         prod_ff <= PROD_W'(diff_ff) * PROD_W'($signed({1'b0, f_ff}));
         lo2_ff  <= lo1_ff;
      end
   end

   assign sum    = {{(SUM_W - tgi_pkg::DATA_W){lo2_ff[tgi_pkg::DATA_W-1]}}, lo2_ff}
                 + prod_ff[PROD_W-1:tgi_pkg::FRAC_W];
   assign result = sum[tgi_pkg::DATA_W-1:0];
   assign done   = v2_ff;

endmodule

/* sim/trilinear_grid_interpolator_core_tb.sv */
// self-checking testbench for trilinear_grid_interpolator_core: directed and random transactions
// checked against a behavioral trilinear predictor with its own grid copy and register mirror
// depends on tgi_pkg and the core rtl

module trilinear_grid_interpolator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_LIMIT    = 40;
   localparam logic [tgi_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   tgi_pkg::req_type              req_data;
   logic                          rsp_strobe;
   tgi_pkg::rsp_type              rsp_data;
   logic                          csr_we;
   logic [tgi_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tgi_pkg::DATA_W-1:0]    csr_wdata;

   logic signed [tgi_pkg::DATA_W-1:0] origin_reg [3];
   logic [tgi_pkg::DATA_W-1:0]        inv_reg [3];
   logic [tgi_pkg::NCOMP_W-1:0]       comps_reg;
   logic signed [tgi_pkg::DATA_W-1:0] grid_copy [tgi_pkg::STORE_WORDS];
   bit                                grid_loaded [tgi_pkg::STORE_WORDS];
   tgi_pkg::rsp_type                  interp_due [$];
   int                                mismatch_count = 0;
   int                                quiet_cycles = 0;
   bit                                gaps_on = 1'b1;

   trilinear_grid_interpolator_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int word_index(input int i, input int j, input int k, input int c);
      return ((k * tgi_pkg::GRID_NY + j) * tgi_pkg::GRID_NX + i) * tgi_pkg::MAX_COMPS + c;
   endfunction

   function automatic longint stored_sample(input int i, input int j, input int k, input int c);
      return longint'(grid_copy[word_index(i, j, k, c)]);
   endfunction

   function automatic int active_comps();
      int nc;
      nc = int'(comps_reg);
      if (nc < 1) nc = 1;
      if (nc > tgi_pkg::COMP_LIMIT) nc = tgi_pkg::COMP_LIMIT;
      return nc;
   endfunction

   function automatic int axis_size(input int axis);
      return (axis == 0) ? tgi_pkg::GRID_NX : ((axis == 1) ? tgi_pkg::GRID_NY : tgi_pkg::GRID_NZ);
   endfunction

   function automatic bit locate_axis(input logic signed [tgi_pkg::DATA_W-1:0] pos,
                                      input logic signed [tgi_pkg::DATA_W-1:0] org,
                                      input logic [tgi_pkg::DATA_W-1:0] inv, input int n,
                                      output int lower,
                                      output logic [tgi_pkg::FRAC_W-1:0] frac);
      longint   offs;
      bit [63:0] prod;
      bit [63:0] q;
      lower = 0;
      frac = '0;
      offs = longint'(pos) - longint'(org);
      if (offs < 0) return 1'b0;
      prod = offs;
      prod = prod * {32'd0, inv};
      if (prod < 64'h8000_0000) return 1'b0;
      q = prod - 64'h8000_0000;
      if ((q >> 32) > 64'(n - 2)) return 1'b0;
      lower = int'(q[35:32]);
      frac = q[31:16];
      return 1'b1;
   endfunction

   function automatic longint blend(input longint lo, input longint hi,
                                    input logic [tgi_pkg::FRAC_W-1:0] f);
      longint s;
      s = lo * (65536 - longint'(f)) + hi * longint'(f);
      return s >>> 16;
   endfunction

   function automatic void trilinear_predict(input tgi_pkg::req_type t);
      int                         lower [3];
      logic [tgi_pkg::FRAC_W-1:0] frac [3];
      bit                         ok_x, ok_y, ok_z, ok;
      int                         nc, i, j, k;
      longint                     x00, x10, x01, x11, y0, y1, v;
      tgi_pkg::rsp_type           r;
      if (t.op == tgi_pkg::OP_WRITE) begin
         i = word_index(t.cell_i, t.cell_j, t.cell_k, t.comp_sel);
         grid_copy[i] = t.sample_value;
         grid_loaded[i] = 1'b1;
         return;
      end
      nc = active_comps();
      ok_x = locate_axis(t.pos_x, origin_reg[0], inv_reg[0], tgi_pkg::GRID_NX,
                         lower[0], frac[0]);
      ok_y = locate_axis(t.pos_y, origin_reg[1], inv_reg[1], tgi_pkg::GRID_NY,
                         lower[1], frac[1]);
      ok_z = locate_axis(t.pos_z, origin_reg[2], inv_reg[2], tgi_pkg::GRID_NZ,
                         lower[2], frac[2]);
      ok = ok_x & ok_y & ok_z;
      i = lower[0];
      j = lower[1];
      k = lower[2];
      for (int c = 0; c < nc; c++) begin
         v = 0;
         if (ok) begin
            x00 = blend(stored_sample(i, j, k, c), stored_sample(i + 1, j, k, c), frac[0]);
            x10 = blend(stored_sample(i, j + 1, k, c),
                        stored_sample(i + 1, j + 1, k, c), frac[0]);
            x01 = blend(stored_sample(i, j, k + 1, c),
                        stored_sample(i + 1, j, k + 1, c), frac[0]);
            x11 = blend(stored_sample(i, j + 1, k + 1, c),
                        stored_sample(i + 1, j + 1, k + 1, c), frac[0]);
            y0 = blend(x00, x10, frac[1]);
            y1 = blend(x01, x11, frac[1]);
            v = blend(y0, y1, frac[2]);
         end
         r.comp_out = c[tgi_pkg::COMP_W-1:0];
         r.interp_value = v[tgi_pkg::DATA_W-1:0];
         r.out_of_range = !ok;
         r.last = (c == nc - 1);
         interp_due = {interp_due, r};
      end
   endfunction

   function automatic logic [tgi_pkg::DATA_W-1:0] aim_coord(
      input logic signed [tgi_pkg::DATA_W-1:0] org,
      input logic [tgi_pkg::DATA_W-1:0] inv, input int n);
      bit [63:0] target;
      bit [63:0] offs;
      longint    p;
      if (inv == 0) return $urandom;
      target = (64'($urandom_range(n - 2, n - 3)) << 32) + 64'h8000_0000 + 64'($urandom);
      offs = target / {32'd0, inv};
      p = longint'(org) + longint'(offs);
      return p[tgi_pkg::DATA_W-1:0];
   endfunction

   function automatic logic [tgi_pkg::DATA_W-1:0] aim_or_noise(input int axis);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return aim_coord(origin_reg[axis], inv_reg[axis], axis_size(axis));
   endfunction

   function automatic logic [tgi_pkg::DATA_W-1:0] random_origin();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return ($urandom_range(0, 40) - 20) * 65536;
   endfunction

   function automatic logic [tgi_pkg::DATA_W-1:0] random_inv();
      case ($urandom_range(0, 4))
         0: return 32'h0001_0000;
         1: return 32'h0000_4000;
         2: return 32'h0004_0000;
         3: return $urandom_range(32768, 1 << 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [tgi_pkg::DATA_W-1:0] got,
                                  input logic [tgi_pkg::DATA_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   task automatic send_item(input tgi_pkg::req_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      trilinear_predict(t);
   endtask

   task automatic send_write(input int i, input int j, input int k, input int c,
                             input logic [tgi_pkg::DATA_W-1:0] value);
      tgi_pkg::req_type t;
      t.op = tgi_pkg::OP_WRITE;
      t.cell_i = i[tgi_pkg::IDX_W-1:0];
      t.cell_j = j[tgi_pkg::IDX_W-1:0];
      t.cell_k = k[tgi_pkg::IDX_W-1:0];
      t.comp_sel = c[tgi_pkg::COMP_W-1:0];
      t.sample_value = value;
      t.pos_x = $urandom;
      t.pos_y = $urandom;
      t.pos_z = $urandom;
      send_item(t);
   endtask

   // loads any corner sample the query would read before sending it
   task automatic query_point(input logic [tgi_pkg::DATA_W-1:0] px,
                              input logic [tgi_pkg::DATA_W-1:0] py,
                              input logic [tgi_pkg::DATA_W-1:0] pz);
      int                         lower [3];
      logic [tgi_pkg::FRAC_W-1:0] frac [3];
      bit                         ok_x, ok_y, ok_z;
      int                         i, j, k;
      tgi_pkg::req_type           t;
      ok_x = locate_axis(px, origin_reg[0], inv_reg[0], tgi_pkg::GRID_NX, lower[0], frac[0]);
      ok_y = locate_axis(py, origin_reg[1], inv_reg[1], tgi_pkg::GRID_NY, lower[1], frac[1]);
      ok_z = locate_axis(pz, origin_reg[2], inv_reg[2], tgi_pkg::GRID_NZ, lower[2], frac[2]);
      if (ok_x && ok_y && ok_z) begin
         for (int c = 0; c < active_comps(); c++) begin
            for (int corner = 0; corner < 8; corner++) begin
               i = lower[0] + corner[0];
               j = lower[1] + corner[1];
               k = lower[2] + corner[2];
               if (!grid_loaded[word_index(i, j, k, c)]) send_write(i, j, k, c, $urandom);
            end
         end
      end
      t.op = tgi_pkg::OP_QUERY;
      t.cell_i = $urandom;
      t.cell_j = $urandom;
      t.cell_k = $urandom;
      t.comp_sel = $urandom;
      t.sample_value = $urandom;
      t.pos_x = px;
      t.pos_y = py;
      t.pos_z = pz;
      send_item(t);
   endtask

   task automatic drain_results();
      if (interp_due.size() != 0) begin
         start <= 1'b0;
         while (interp_due.size() != 0) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (interp_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [tgi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tgi_pkg::DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_config(input logic [tgi_pkg::DATA_W-1:0] ox,
                               input logic [tgi_pkg::DATA_W-1:0] oy,
                               input logic [tgi_pkg::DATA_W-1:0] oz,
                               input logic [tgi_pkg::DATA_W-1:0] ix,
                               input logic [tgi_pkg::DATA_W-1:0] iy,
                               input logic [tgi_pkg::DATA_W-1:0] iz,
                               input logic [tgi_pkg::NCOMP_W-1:0] nc);
      wait_idle();
      csr_write(tgi_pkg::CSR_ORIGIN_X, ox);
      csr_write(tgi_pkg::CSR_ORIGIN_Y, oy);
      csr_write(tgi_pkg::CSR_ORIGIN_Z, oz);
      csr_write(tgi_pkg::CSR_INV_CELL_X, ix);
      csr_write(tgi_pkg::CSR_INV_CELL_Y, iy);
      csr_write(tgi_pkg::CSR_INV_CELL_Z, iz);
      csr_write(tgi_pkg::CSR_NUM_COMPS, {29'($urandom), nc});
      csr_write(CSR_SPARE, $urandom);
      csr_we <= 1'b0;
      origin_reg[0] = ox;
      origin_reg[1] = oy;
      origin_reg[2] = oz;
      inv_reg[0] = ix;
      inv_reg[1] = iy;
      inv_reg[2] = iz;
      comps_reg = nc;
   endtask

   task automatic run_random_items(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 15) == 0) drain_results();
         r = $urandom_range(0, 99);
         if (r < 70)
            query_point(aim_or_noise(0), aim_or_noise(1), aim_or_noise(2));
         else if (r < 82)
            query_point($urandom, $urandom, $urandom);
         else
            send_write($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 3), $urandom);
      end
   endtask

   // reset register values, full-scale samples, exact corners, fraction limits, range edges
   task automatic test_directed_cases();
      for (int corner = 0; corner < 8; corner++)
         send_write(corner[0], corner[1], corner[2], 0,
                    (corner[0] ^ corner[1] ^ corner[2]) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      send_write(15, 15, 15, 3, $urandom);
      query_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
      query_point(32'h0001_7FFF, 32'h0001_7FFF, 32'h0001_7FFF);
      query_point(32'h0000_C000, 32'h0001_0000, 32'h0001_4000);
      query_point(32'h0000_7FFF, 32'h0000_8000, 32'h0000_8000);
      query_point(32'h8000_0000, 32'h0000_8000, 32'h0000_8000);
      query_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      query_point(32'h0000_8000, 32'h0000_8000, 32'h000F_8000);
   endtask

   task automatic test_config_extremes();
      write_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1, 3'd7);
      run_random_items(15);
      write_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4);
      run_random_items(15);
   endtask

   task automatic test_component_counts();
      for (int nc = 0; nc < 8; nc++) begin
         write_config(random_origin(), random_origin(), random_origin(),
                      32'h0001_0000, 32'h0001_0000, 32'h0001_0000, nc[tgi_pkg::NCOMP_W-1:0]);
         run_random_items(6);
      end
   endtask

   task automatic test_random_sweep();
      for (int phase = 0; phase < 6; phase++) begin
         write_config(random_origin(), random_origin(), random_origin(),
                      random_inv(), random_inv(), random_inv(), tgi_pkg::NCOMP_W'($urandom));
         gaps_on = (phase != 3);
         run_random_items(30);
      end
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin
      tgi_pkg::rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (interp_due.size() == 0) begin
            report_mismatch("result with no transaction pending", rsp_data.interp_value, '0);
         end else begin
            want = interp_due.pop_front();
            if (rsp_data.comp_out !== want.comp_out)
               report_mismatch("comp_out", rsp_data.comp_out, want.comp_out);
            if (rsp_data.interp_value !== want.interp_value)
               report_mismatch("interp_value", rsp_data.interp_value, want.interp_value);
            if (rsp_data.out_of_range !== want.out_of_range)
               report_mismatch("out_of_range", rsp_data.out_of_range, want.out_of_range);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1 || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      origin_reg[0] = '0;
      origin_reg[1] = '0;
      origin_reg[2] = '0;
      inv_reg[0] = 32'h0001_0000;
      inv_reg[1] = 32'h0001_0000;
      inv_reg[2] = 32'h0001_0000;
      comps_reg = 3'd1;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_config_extremes();
      test_component_counts();
      test_random_sweep();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/tgi_pkg.sv
hw/rtl/tgi_lerp.sv
hw/rtl/trilinear_grid_interpolator_core.sv
sim/trilinear_grid_interpolator_core_tb.sv
